### rtl/core/accel_tilt_pitch_roll_macros.svh
// assertion helpers for the tilt pipeline
`ifndef ACCEL_TILT_PITCH_ROLL_MACROS_SVH
`define ACCEL_TILT_PITCH_ROLL_MACROS_SVH

// generic clocked check, off while in reset
`define ATPR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tilt pipeline check failed");

// two signals that must agree every cycle
`define ATPR_ASSERT_EQ(name, a, b) \
  `ATPR_ASSERT(name, (a) == (b))

`endif

### rtl/core/atpr_pkg.sv
package atpr_pkg;

  localparam int RAD_W    = 32;
  localparam int DAT_W    = 36;
  localparam int Z_W      = 34;
  localparam int TAB_LEN  = 24;
  localparam int DEG_TURN = 360;
  localparam logic [Z_W-1:0] QUARTER_TURN = Z_W'(64'd1 << 30);

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/atpr_isqrt.sv
module atpr_isqrt #(
  parameter int SIDE_W = 49
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic [2*atpr_pkg::RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             vld_o,
  output logic [atpr_pkg::RAD_W-1:0]       root_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int RW = atpr_pkg::RAD_W;

  logic              vld_q  [1:RW];
  logic [RW+1:0]     rem_q  [1:RW];
  logic [RW-1:0]     root_q [1:RW];
  logic [2*RW-1:0]   rad_q  [1:RW];
  logic [SIDE_W-1:0] side_q [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              pv;
    logic [RW+1:0]     prem;
    logic [RW-1:0]     proot;
    logic [2*RW-1:0]   prad;
    logic [SIDE_W-1:0] pside;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign pv    = vld_i;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = rad_i;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = vld_q[k];
      assign prem  = rem_q[k];
      assign proot = root_q[k];
      assign prad  = rad_q[k];
      assign pside = side_q[k];
    end

    // one root bit per stage
    assign rem_sh = {prem[RW-1:0], prad[2*RW-1 -: 2]};
    assign trial  = {proot, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k+1] <= {proot[RW-2:0], take};
        rad_q[k+1]  <= {prad[2*RW-3:0], 2'b00};
        side_q[k+1] <= pside;
      end
    end
  end

  assign vld_o  = vld_q[RW];
  assign root_o = root_q[RW];
  assign side_o = side_q[RW];

endmodule

### rtl/core/atpr_cordic.sv
module atpr_cordic #(
  parameter int STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic                               tag_i,
  input  logic signed [atpr_pkg::DAT_W-1:0]  x_i,
  input  logic signed [atpr_pkg::DAT_W-1:0]  y_i,
  output logic                               vld_o,
  output logic                               tag_o,
  output logic signed [atpr_pkg::Z_W-1:0]    z_o
);

  localparam int DW = atpr_pkg::DAT_W;
  localparam int ZW = atpr_pkg::Z_W;

  logic                 vld_q [0:STEPS];
  logic                 tag_q [0:STEPS];
  logic signed [DW-1:0] x_q   [0:STEPS];
  logic signed [DW-1:0] y_q   [0:STEPS];
  logic signed [ZW-1:0] z_q   [0:STEPS];

  // quarter turn towards the right half plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      if (!x_i[DW-1]) begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end else if (!y_i[DW-1]) begin
        x_q[0] <= y_i;
        y_q[0] <= -x_i;
        z_q[0] <= $signed(atpr_pkg::QUARTER_TURN);
      end else begin
        x_q[0] <= -y_i;
        y_q[0] <= x_i;
        z_q[0] <= -$signed(atpr_pkg::QUARTER_TURN);
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic signed [ZW-1:0] ang;
    logic                 cw;

    assign xs  = x_q[i] >>> i;
    assign ys  = y_q[i] >>> i;
    assign ang = $signed(ZW'(atpr_pkg::atan_tab(i)));
    assign cw  = !y_q[i][DW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i+1] <= tag_q[i];
        if (cw) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + ang;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - ang;
        end
      end
    end
  end

  assign vld_o = vld_q[STEPS];
  assign tag_o = tag_q[STEPS];
  assign z_o   = z_q[STEPS];

endmodule

### rtl/core/atpr_deg.sv
module atpr_deg #(
  parameter int FRAC  = 8,
  parameter int LIMIT = 90,
  parameter int OUT_W = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic                            tag_i,
  input  logic signed [atpr_pkg::Z_W-1:0] z_i,
  output logic                            vld_o,
  output logic                            ok_o,
  output logic signed [OUT_W-1:0]         ang_o
);

  localparam int ZW  = atpr_pkg::Z_W;
  localparam int MW  = ZW + 9;
  localparam int TW  = MW + 1;
  localparam int DW  = TW - (32 - FRAC);

  logic              vld1_q;
  logic              tag1_q;
  logic              neg1_q;
  logic [MW-1:0]     prod1_q;
  logic [ZW-1:0]     mag;

  logic [TW-1:0]     rnd;
  logic [DW-1:0]     d;
  logic [DW-1:0]     lim;
  logic [DW-1:0]     dsat;
  logic signed [DW:0] res;

  logic              vld2_q;
  logic              ok2_q;
  logic signed [OUT_W-1:0] ang2_q;

  assign mag = z_i[ZW-1] ? ZW'(-z_i) : ZW'(z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag1_q  <= tag_i;
      neg1_q  <= z_i[ZW-1];
      prod1_q <= MW'(mag) * MW'(atpr_pkg::DEG_TURN);
    end
  end

  // round half away from zero, then clamp the magnitude
  assign rnd  = TW'(prod1_q) + (TW'(1) << (31 - FRAC));
  assign d    = DW'(rnd >> (32 - FRAC));
  assign lim  = DW'(LIMIT) << FRAC;
  assign dsat = (d > lim) ? lim : d;
  assign res  = neg1_q ? -$signed({1'b0, dsat}) : $signed({1'b0, dsat});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok2_q  <= !tag1_q;
      ang2_q <= tag1_q ? '0 : OUT_W'(res);
    end
  end

  assign vld_o = vld2_q;
  assign ok_o  = ok2_q;
  assign ang_o = ang2_q;

endmodule

### rtl/core/accel_tilt_pitch_roll.sv
// path from input to result: input, square, sum, square root, CORDIC and degree stages
// throughput: one sample per cycle unless the output stalls; the whole pipeline advances together
// the pipeline stalls only while a result waits at the output and m_axis_tready_i is low
// the depth is set by the 32 digit square root and the CORDIC steps, one per stage
// reset clears all valid bits; data registers are not reset
`include "accel_tilt_pitch_roll_macros.svh"

module accel_tilt_pitch_roll #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // accel_x, accel_y, accel_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // pitch_deg, roll_deg, zero fill
  output logic [0:0]  m_axis_tuser_o    // angle_valid
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int G      = 32 - SW;
  localparam int STEPS  = (CORDIC_STEPS < atpr_pkg::TAB_LEN) ? CORDIC_STEPS
                                                            : atpr_pkg::TAB_LEN;
  localparam int SIDE_W = 3 * SW + 1;
  localparam int RW     = atpr_pkg::RAD_W;
  localparam int DW     = atpr_pkg::DAT_W;
  localparam int ZW     = atpr_pkg::Z_W;

  logic en;

  logic                 vld_a_q;
  logic signed [SW-1:0] ax_a_q, ay_a_q, az_a_q;

  logic                   vld_b_q;
  logic                   zero_b_q;
  logic signed [SW-1:0]   ax_b_q, ay_b_q, az_b_q;
  logic signed [2*SW-1:0] sqy_b_q, sqz_b_q;

  logic                vld_c_q;
  logic [2*SW-1:0]     sum_c_q;
  logic [SIDE_W-1:0]   side_c_q;

  logic                vld_r;
  logic [RW-1:0]       root_r;
  logic [SIDE_W-1:0]   side_r;
  logic                zero_r;
  logic signed [SW-1:0] ax_r, ay_r, az_r;

  logic signed [DW-1:0] px, py, rx, ry;

  logic                 p_vld, p_tag, r_vld, r_tag;
  logic signed [ZW-1:0] p_z, r_z;

  logic                 po_vld, po_ok, ro_vld, ro_ok;
  logic signed [15:0]   pitch;
  logic signed [16:0]   roll;

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= s_axis_tvalid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_a_q   <= $signed(SW'({16'b0, s_axis_tdata_i[15:0]}));
      ay_a_q   <= $signed(SW'({16'b0, s_axis_tdata_i[31:16]}));
      az_a_q   <= $signed(SW'({16'b0, s_axis_tdata_i[47:32]}));
      ax_b_q   <= ax_a_q;
      ay_b_q   <= ay_a_q;
      az_b_q   <= az_a_q;
      zero_b_q <= (ay_a_q == '0) && (az_a_q == '0);
      sqy_b_q  <= ay_a_q * ay_a_q;
      sqz_b_q  <= az_a_q * az_a_q;
      sum_c_q  <= $unsigned(sqy_b_q) + $unsigned(sqz_b_q);
      side_c_q <= {zero_b_q, ax_b_q, ay_b_q, az_b_q};
    end
  end

  atpr_isqrt #(
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_c_q),
    .rad_i  ((2 * RW)'(sum_c_q) << (2 * G)),
    .side_i (side_c_q),
    .vld_o  (vld_r),
    .root_o (root_r),
    .side_o (side_r)
  );

  assign {zero_r, ax_r, ay_r, az_r} = side_r;

  assign px = $signed(DW'(root_r));
  assign py = DW'($signed(32'(ax_r)) <<< G);
  assign rx = DW'($signed(32'(az_r)) <<< G);
  assign ry = DW'($signed(32'(ay_r)) <<< G);

  atpr_cordic #(
    .STEPS (STEPS)
  ) u_cordic_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_r),
    .tag_i  (zero_r),
    .x_i    (px),
    .y_i    (py),
    .vld_o  (p_vld),
    .tag_o  (p_tag),
    .z_o    (p_z)
  );

  atpr_cordic #(
    .STEPS (STEPS)
  ) u_cordic_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_r),
    .tag_i  (zero_r),
    .x_i    (rx),
    .y_i    (ry),
    .vld_o  (r_vld),
    .tag_o  (r_tag),
    .z_o    (r_z)
  );

  atpr_deg #(
    .FRAC  (ANGLE_FRAC_BITS),
    .LIMIT (90),
    .OUT_W (16)
  ) u_deg_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p_vld),
    .tag_i  (p_tag),
    .z_i    (p_z),
    .vld_o  (po_vld),
    .ok_o   (po_ok),
    .ang_o  (pitch)
  );

  atpr_deg #(
    .FRAC  (ANGLE_FRAC_BITS),
    .LIMIT (180),
    .OUT_W (17)
  ) u_deg_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (r_vld),
    .tag_i  (r_tag),
    .z_i    (r_z),
    .vld_o  (ro_vld),
    .ok_o   (ro_ok),
    .ang_o  (roll)
  );

  assign m_axis_tvalid_o = po_vld;
  assign m_axis_tdata_o  = {7'b0, roll, pitch};
  assign m_axis_tuser_o  = po_ok;

  `ATPR_ASSERT_EQ(a_lanes_valid, po_vld, ro_vld)
  `ATPR_ASSERT(a_lanes_ok, !po_vld || (po_ok == ro_ok))
  `ATPR_ASSERT(a_invalid_zero, (po_vld && !po_ok) |-> (pitch == '0 && roll == '0))
  `ATPR_ASSERT(a_stall_cause, !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))

endmodule

### tb/accel_tilt_pitch_roll_tb.sv
module accel_tilt_pitch_roll_tb;

  localparam int SW          = 16;
  localparam int FRAC        = 8;
  localparam int STEPS       = 16;
  localparam int N_RANDOM    = 450;
  localparam int LATENCY     = 54;
  localparam int IDLE_LIMIT  = 20000;

  typedef struct packed {
    logic signed [16:0] roll;
    logic signed [15:0] pitch;
    logic               ok;
  } tilt_t;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    bit                 typed;
    tilt_t              want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  accel_tilt_pitch_roll u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  tilt_t pending_angles[$];
  int    n_mismatch;
  int    idle_cycles;
  bit    hold_sink;
  bit    hold_req;
  bit    stim_done;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z;
    longint t;
    longint nx;
    longint ny;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 64'sd1 << 30;
      end else begin
        x = -y;
        y = t;
        z = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += longint'(atpr_pkg::atan_tab(i));
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= longint'(atpr_pkg::atan_tab(i));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint turn_to_deg(longint z, longint lim_deg);
    bit     neg;
    longint m;
    longint d;
    neg = z < 0;
    m = neg ? -z : z;
    d = ((m * 360) * (64'sd1 << FRAC) + (64'sd1 << 31)) >>> 32;
    if (d > (lim_deg << FRAC)) d = lim_deg << FRAC;
    return neg ? -d : d;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic tilt_t tilt_of(logic signed [15:0] ax, logic signed [15:0] ay,
                                    logic signed [15:0] az);
    tilt_t           res;
    longint          x;
    longint          y;
    longint          z;
    longint          r;
    longint unsigned sq;
    res = '0;
    x = ax;
    y = ay;
    z = az;
    if (y == 0 && z == 0) return res;
    sq = y * y + z * z;
    sq = sq << (2 * (32 - SW));
    r = longint'(root_floor(sq));
    res.pitch = 16'(turn_to_deg(cordic_angle(r, x <<< (32 - SW)), 90));
    res.roll  = 17'(turn_to_deg(cordic_angle(z <<< (32 - SW), y <<< (32 - SW)), 180));
    res.ok    = 1'b1;
    return res;
  endfunction

  task automatic pause_random();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             bit typed, tilt_t want);
    tilt_t calc;
    calc = tilt_of(ax, ay, az);
    if (typed && calc !== want) $display("table row disagrees with predictor");
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {az, ay, ax};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_angles.push_back(typed ? want : calc);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 6)) - 3);
      3: return 16'(int'($urandom_range(0, 2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    row_t        dir_rows[$];
    row_t        rw;
    logic [15:0] ay;
    logic [15:0] az;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    stim_done       = 1'b0;
    hold_req        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // y and z zero: guard
    dir_rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1, '{17'sd0, 16'sd0, 1'b0}});
    dir_rows.push_back('{16'sh7fff, 16'sd0, 16'sd0, 1, '{17'sd0, 16'sd0, 1'b0}});
    dir_rows.push_back('{-16'sd32768, 16'sd0, 16'sd0, 1, '{17'sd0, 16'sd0, 1'b0}});
    // roll with y zero and z negative, then other axis directions and corner values
    dir_rows.push_back('{16'sd0, 16'sd0, -16'sd1000, 0, '0});
    dir_rows.push_back('{16'sd0, 16'sd0, -16'sd32768, 0, '0});
    dir_rows.push_back('{16'sd0, 16'sd0, 16'sd1000, 0, '0});
    dir_rows.push_back('{16'sd0, 16'sd1000, 16'sd0, 0, '0});
    dir_rows.push_back('{16'sd0, -16'sd1000, 16'sd0, 0, '0});
    dir_rows.push_back('{16'sh7fff, 16'sd0, 16'sd1, 0, '0});
    dir_rows.push_back('{-16'sd32768, 16'sd1, 16'sd0, 0, '0});
    dir_rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 0, '0});
    dir_rows.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, 0, '0});
    dir_rows.push_back('{16'sd1000, -16'sd1, -16'sd32768, 0, '0});
    dir_rows.push_back('{-16'sd1, 16'sd1, -16'sd1, 0, '0});
    dir_rows.push_back('{16'sh5555, -16'sh5556, 16'sh2aaa, 0, '0});
    dir_rows.push_back('{16'sd707, 16'sd707, 16'sd0, 0, '0});
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      send_sample(rw.ax, rw.ay, rw.az, rw.typed, rw.want);
      pause_random();
    end

    // sender waits for the pipeline to drain
    s_axis_tvalid_i <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      ay = rand_axis();
      az = rand_axis();
      if ($urandom_range(0, 19) == 0) begin
        ay = '0;
        az = '0;
      end
      if (n == 100) hold_req = 1'b1;
      send_sample(rand_axis(), ay, az, 0, '0);
      if (n % 3 != 0) begin
        pause_random();
      end
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    m_axis_tready_i = 1'b0;
    hold_sink       = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_sink && hold_req) begin
        // long back-pressure: block fills and must stall its input
        hold_sink = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
      end else if ($urandom_range(0, 29) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    tilt_t want;
    tilt_t got;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.pitch = m_axis_tdata_o[15:0];
        got.roll  = m_axis_tdata_o[32:16];
        got.ok    = m_axis_tuser_o[0];
        if (pending_angles.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected transfer: pitch %0d roll %0d ok %0b",
                                         got.pitch, got.roll, got.ok);
        end else begin
          want = pending_angles.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: pitch %0d/%0d roll %0d/%0d ok %0b/%0b (exp/act)",
                       want.pitch, got.pitch, want.roll, got.roll, want.ok, got.ok);
          end
        end
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    n_mismatch  = 0;
    idle_cycles = 0;
    wait (stim_done);
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY * 2) @(posedge clk_i);
    if (n_mismatch == 0 && pending_angles.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
